// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

   localparam int NUM_FRAMES_DEF = 4;
   localparam int PAGE_BITS_DEF  = 8;

   localparam int PAGE_BITS_MAX = 16;
   localparam int SLOT_BITS_MAX = 3;

   localparam int                     COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

   typedef struct packed {
      logic                     valid;
      logic [PAGE_BITS_MAX-1:0] page;
      logic                     hit;
      logic [SLOT_BITS_MAX-1:0] hit_slot;
      logic [SLOT_BITS_MAX-1:0] hit_rank;
      logic                     empty;
      logic [SLOT_BITS_MAX-1:0] empty_slot;
      logic [SLOT_BITS_MAX-1:0] empty_rank;
      logic                     lru_any;
      logic [SLOT_BITS_MAX-1:0] lru_slot;
      logic [SLOT_BITS_MAX-1:0] lru_rank;
      logic [PAGE_BITS_MAX-1:0] lru_page;
   } scan_type;

   typedef struct packed {
      logic                     apply;
      logic                     write;
      logic [SLOT_BITS_MAX-1:0] slot;
      logic [SLOT_BITS_MAX-1:0] old_rank;
      logic [PAGE_BITS_MAX-1:0] page;
   } upd_type;

endpackage

// ===== rtl/lru_page_replacement_core.sv =====
// LRU page replacement core. Each request word carries one page id; each response word
// reports whether it faulted, the frame it hit or filled, the page evicted from that frame
// (zero when none) and the saturating fault count. Page zero is ignored and leaves the state
// untouched. A search record walks the chain of frame cells one frame per cycle into a pending
// register, and the response word is registered from it once the response side is free. The
// core stalls new references until the current one has produced its response word.
module lru_page_replacement_core
   import lpr_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PAGE_BITS-1:0]          req_page,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_fault,
   output logic [$clog2(NUM_FRAMES)-1:0] rsp_slot,
   output logic [PAGE_BITS-1:0]          rsp_evicted_page,
   output logic [COUNT_BITS-1:0]         rsp_fault_total
);

   localparam int SB = $clog2(NUM_FRAMES);

   scan_type              link_w [NUM_FRAMES+1];
   scan_type              pend_ff;
   upd_type               upd;
   logic                  busy_ff;
   logic                  accept;
   logic                  out_free;
   logic                  finish;
   logic                  zero_page;
   logic                  fault;
   logic [SB-1:0]         slot;
   logic [SB-1:0]         old_rank;
   logic [PAGE_BITS-1:0]  evicted;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_fault_ff;
   logic [SB-1:0]         rsp_slot_ff;
   logic [PAGE_BITS-1:0]  rsp_evicted_ff;
   logic [COUNT_BITS-1:0] rsp_total_ff;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = pend_ff.valid && out_free;

   always_comb begin
      link_w[0]       = '0;
      link_w[0].valid = accept;
      link_w[0].page  = PAGE_BITS_MAX'(req_page);
   end

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_frame
      lpr_cell #(
         .NUM_FRAMES (NUM_FRAMES),
         .PAGE_BITS  (PAGE_BITS),
         .INDEX      (i)
      ) u_frame (
         .clock  (clock),
         .reset  (reset),
         .scan_i (link_w[i]),
         .upd_i  (upd),
         .scan_o (link_w[i+1])
      );
   end

   always_comb begin
      zero_page = (pend_ff.page[PAGE_BITS-1:0] == '0);
      fault     = !zero_page && !pend_ff.hit;
      evicted   = '0;
      if (zero_page) begin
         slot     = '0;
         old_rank = '0;
      end else if (pend_ff.hit) begin
         slot     = pend_ff.hit_slot[SB-1:0];
         old_rank = pend_ff.hit_rank[SB-1:0];
      end else if (pend_ff.empty) begin
         slot     = pend_ff.empty_slot[SB-1:0];
         old_rank = pend_ff.empty_rank[SB-1:0];
      end else begin
         slot     = pend_ff.lru_slot[SB-1:0];
         old_rank = pend_ff.lru_rank[SB-1:0];
         evicted  = pend_ff.lru_page[PAGE_BITS-1:0];
      end
      count_in = count_ff;
      if (fault && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
      upd.apply    = finish && !zero_page;
      upd.write    = !pend_ff.hit;
      upd.slot     = SLOT_BITS_MAX'(slot);
      upd.old_rank = SLOT_BITS_MAX'(old_rank);
      upd.page     = pend_ff.page;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_ff.valid <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (link_w[NUM_FRAMES].valid) begin
            pend_ff <= link_w[NUM_FRAMES];
         end else if (finish) begin
            pend_ff.valid <= 1'b0;
         end
         if (finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_fault_ff   <= fault;
         rsp_slot_ff    <= slot;
         rsp_evicted_ff <= evicted;
         rsp_total_ff   <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted_page = rsp_evicted_ff;
   assign rsp_fault_total  = rsp_total_ff;

   a_pend_needs_busy : assert property (@(posedge clock) disable iff (reset)
      pend_ff.valid |-> busy_ff)
      else $error("pending search record without a reference in flight");

   a_finish_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && (rsp_total_ff == count_ff))
      else $error("finished reference did not produce a response word");

   a_count_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("fault count decreased");

   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      finish && pend_ff.hit |=> !rsp_fault_ff && (rsp_evicted_ff == '0))
      else $error("hit reported a fault or an eviction");

endmodule

// ===== rtl/lpr_cell.sv =====
module lpr_cell
   import lpr_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int INDEX      = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  scan_type scan_i,
   input  upd_type  upd_i,
   output scan_type scan_o
);

   localparam int             SB        = $clog2(NUM_FRAMES);
   localparam logic [SB-1:0] MY_SLOT   = SB'(INDEX);
   localparam logic [SB-1:0] LAST_RANK = SB'(NUM_FRAMES - 1);

   logic [PAGE_BITS-1:0] page_ff;
   logic [SB-1:0]        rank_ff;
   scan_type             scan_in;
   scan_type             scan_ff;

   // Each frame folds its own entry into the search record passing by.
   always_comb begin
      scan_in = scan_i;
      if (!scan_i.hit && (page_ff == scan_i.page[PAGE_BITS-1:0])) begin
         scan_in.hit      = 1'b1;
         scan_in.hit_slot = SLOT_BITS_MAX'(MY_SLOT);
         scan_in.hit_rank = SLOT_BITS_MAX'(rank_ff);
      end
      if (!scan_i.empty && (page_ff == '0)) begin
         scan_in.empty      = 1'b1;
         scan_in.empty_slot = SLOT_BITS_MAX'(MY_SLOT);
         scan_in.empty_rank = SLOT_BITS_MAX'(rank_ff);
      end
      if (!scan_i.lru_any || (rank_ff < scan_i.lru_rank[SB-1:0])) begin
         scan_in.lru_any  = 1'b1;
         scan_in.lru_slot = SLOT_BITS_MAX'(MY_SLOT);
         scan_in.lru_rank = SLOT_BITS_MAX'(rank_ff);
         scan_in.lru_page = PAGE_BITS_MAX'(page_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         rank_ff <= MY_SLOT;
      end else if (upd_i.apply) begin
         if (upd_i.slot[SB-1:0] == MY_SLOT) begin
            rank_ff <= LAST_RANK;
            if (upd_i.write) begin
               page_ff <= upd_i.page[PAGE_BITS-1:0];
            end
         end else if (rank_ff > upd_i.old_rank[SB-1:0]) begin
            rank_ff <= rank_ff - SB'(1);
         end
      end
   end

   assign scan_o = scan_ff;

endmodule
